>>> rtl/tanimoto_leader_clustering_core_macros.svh
// assertion helpers shared by the rtl
`ifndef TANIMOTO_LEADER_CLUSTERING_CORE_MACROS_SVH
`define TANIMOTO_LEADER_CLUSTERING_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tlc_pkg.sv
package tlc_pkg;

	localparam int FP_WORD_W = 16;
	localparam int ONES_W    = 11;
	localparam int WPP_W     = 7;
	localparam int THR_W     = 17;
	localparam int LIMIT_W   = 10;
	localparam int CLUST_W   = 10;
	localparam int MOL_W     = 10;
	localparam int SIM_W     = 17;
	localparam int SIM_FRAC  = 16;

	localparam logic [1:0] REG_WPP   = 2'd0;
	localparam logic [1:0] REG_THR   = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	typedef struct packed {
		logic start;
		logic force_sim;
	} sim_req_t;

	typedef struct packed {
		logic done;
		logic joins;
	} sim_rsp_t;

	function automatic logic [4:0] popcount16(input logic [15:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			n = n + 5'(v[i]);
		end
		return n;
	endfunction

endpackage

>>> rtl/tlc_cmd_if.sv
interface tlc_cmd_if import tlc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [FP_WORD_W-1:0] fp_word;
	logic [ONES_W-1:0]    bit_count;

	modport source(output valid, func, fp_word, bit_count, input ready);
	modport sink(input valid, func, fp_word, bit_count, output ready);
endinterface

>>> rtl/tlc_res_if.sv
interface tlc_res_if import tlc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CLUST_W-1:0] cluster_number;
	logic [MOL_W-1:0]   molecule_number;
	logic [SIM_W-1:0]   similarity;
	logic               is_head;
	logic               done_res;

	modport source(output valid, cluster_number, molecule_number, similarity, is_head,
		done_res, input ready);
	modport sink(input valid, cluster_number, molecule_number, similarity, is_head,
		done_res, output ready);
endinterface

>>> rtl/tlc_print_mem.sv
module tlc_print_mem import tlc_pkg::*; #(
	parameter int MW = 10,
	parameter int WW = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [MW+WW-1:0]     waddr,
	input  logic [FP_WORD_W-1:0] wdata,
	input  logic [MW+WW-1:0]     raddr_a,
	input  logic [MW+WW-1:0]     raddr_b,
	output logic [FP_WORD_W-1:0] rdata_a,
	output logic [FP_WORD_W-1:0] rdata_b,
	input  logic                 ones_we,
	input  logic [MW-1:0]        ones_waddr,
	input  logic [ONES_W-1:0]    ones_wdata,
	input  logic [MW-1:0]        ones_raddr_a,
	input  logic [MW-1:0]        ones_raddr_b,
	output logic [ONES_W-1:0]    ones_rdata_a,
	output logic [ONES_W-1:0]    ones_rdata_b
);

	logic [FP_WORD_W-1:0] words_mem [2**(MW+WW)];
	logic [ONES_W-1:0]    ones_mem [2**MW];

	always_ff @(posedge clk) begin
		if (we) begin
			words_mem[waddr] <= wdata;
		end
		rdata_a <= words_mem[raddr_a];
		rdata_b <= words_mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (ones_we) begin
			ones_mem[ones_waddr] <= ones_wdata;
		end
		ones_rdata_a <= ones_mem[ones_raddr_a];
		ones_rdata_b <= ones_mem[ones_raddr_b];
	end

endmodule

>>> rtl/tlc_list_mem.sv
module tlc_list_mem #(
	parameter int MW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [MW:0]   waddr,
	input  logic [MW-1:0] wdata,
	input  logic [MW:0]   raddr,
	output logic [MW-1:0] rdata
);

	// two banks: current pass and next pass
	logic [MW-1:0] list_mem [2**(MW+1)];

	always_ff @(posedge clk) begin
		if (we) begin
			list_mem[waddr] <= wdata;
		end
		rdata <= list_mem[raddr];
	end

endmodule

>>> rtl/tlc_sim.sv
module tlc_sim import tlc_pkg::*; #(
	parameter int IW = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sim_req_t          req,
	input  logic [IW-1:0]     inter,
	input  logic [ONES_W-1:0] ones_a,
	input  logic [ONES_W-1:0] ones_b,
	input  logic [THR_W-1:0]  thr,
	output sim_rsp_t          rsp,
	output logic [SIM_W-1:0]  sim
);

	localparam int UW = ((IW > ONES_W) ? IW : ONES_W) + 2;
	localparam int PW = UW + THR_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_TEST = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]          state_q;
	logic signed [UW-1:0] uni_q;
	logic [IW-1:0]       inter_q;
	logic                force_q;
	logic [PW-1:0]       prod_q;
	logic [UW-1:0]       rem_q;
	logic [SIM_FRAC-1:0] quo_q;
	logic [3:0]          cnt_q;
	logic                joins_q;
	logic [SIM_W-1:0]    sim_q;

	logic [UW-2:0] uni_mag;
	logic [PW-1:0] lhs;
	logic          join_now;
	logic [UW-1:0] rem_sh;
	logic          sub_ok;

	assign uni_mag  = uni_q[UW-2:0];
	assign lhs      = PW'({inter_q, {SIM_FRAC{1'b0}}});
	assign join_now = lhs > prod_q;
	assign rem_sh   = {rem_q[UW-2:0], 1'b0};
	assign sub_ok   = rem_sh >= UW'(uni_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.start) state_q <= S_MUL;
				S_MUL:  state_q <= (uni_q <= 0) ? S_DONE : S_TEST;
				S_TEST: begin
					if ((join_now || force_q) && (UW'(inter_q) < UW'(uni_mag))) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV:  if (cnt_q == 4'd15) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				uni_q   <= $signed(UW'(ones_a) + UW'(ones_b) - UW'(inter));
				inter_q <= inter;
				force_q <= req.force_sim;
			end
			S_MUL: begin
				prod_q  <= PW'(thr) * PW'(uni_mag);
				joins_q <= 1'b0;
				sim_q   <= '0;
			end
			S_TEST: begin
				joins_q <= join_now;
				rem_q   <= UW'(inter_q);
				cnt_q   <= '0;
				// similarity of one or more saturates
				if (UW'(inter_q) >= UW'(uni_mag)) begin
					sim_q <= SIM_W'(1) << SIM_FRAC;
				end
			end
			S_DIV: begin
				rem_q <= sub_ok ? (rem_sh - UW'(uni_mag)) : rem_sh;
				quo_q <= {quo_q[SIM_FRAC-2:0], sub_ok};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					sim_q <= {1'b0, quo_q[SIM_FRAC-2:0], sub_ok};
				end
			end
			default: ;
		endcase
	end

	assign rsp.done  = state_q == S_DONE;
	assign rsp.joins = joins_q;
	assign sim       = sim_q;

endmodule

>>> rtl/tanimoto_leader_clustering_core.sv
// a pull reads both prints word by word, then tests the join and divides for the similarity
// a pull scans until one member joins; when a pass ends with none, it returns the next head
// loads are taken in the idle state; the word-serial compare loop on the print memory sets the rate
// arst_n clears control, counters and registers to their reset values (load phase)
// memories are not cleared: every entry is written before it is read
`include "tanimoto_leader_clustering_core_macros.svh"

module tanimoto_leader_clustering_core import tlc_pkg::*; #(
	parameter int MAX_MOLECULES = 1024,
	parameter int MAX_WORDS     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tlc_cmd_if.sink     cmd,
	tlc_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int MW = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;
	localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LW = $clog2(MAX_MOLECULES + 1);
	localparam int NW = $clog2(MAX_WORDS + 1);
	localparam int IW = $clog2(MAX_WORDS * 16 + 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHK   = 4'd1;
	localparam logic [3:0] ST_HEAD  = 4'd2;
	localparam logic [3:0] ST_HWAIT = 4'd3;
	localparam logic [3:0] ST_MWAIT = 4'd4;
	localparam logic [3:0] ST_CMP   = 4'd5;
	localparam logic [3:0] ST_CDRN  = 4'd6;
	localparam logic [3:0] ST_CGO   = 4'd7;
	localparam logic [3:0] ST_CWAIT = 4'd8;
	localparam logic [3:0] ST_RES   = 4'd9;

	// configuration registers
	logic [WPP_W-1:0]   wpp_q;
	logic [THR_W-1:0]   thr_q;
	logic [LIMIT_W-1:0] limit_q;

	// control state
	logic [3:0]    state_q;
	logic [LW-1:0] loaded_q;
	logic [WW-1:0] wp_q;
	logic [LW-1:0] rem_q;
	logic [LW-1:0] kept_q;
	logic [LW-1:0] scan_q;
	logic [LW-1:0] cc_q;
	logic          started_q;
	logic          first_q;     // first pass: list is the identity
	logic          bank_q;      // list bank of the current pass
	logic          hmode_q;     // comparing the head with itself
	logic          done_q;

	// compare datapath
	logic [MW-1:0] head_q;
	logic [MW-1:0] cand_q;
	logic [WW-1:0] w_q;
	logic          rv_s1;
	logic [IW-1:0] acc_q;
	logic [SIM_W-1:0] simr_q;

	// result register
	logic               out_vld_q;
	logic [CLUST_W-1:0] out_cl_q;
	logic [MOL_W-1:0]   out_mol_q;
	logic [SIM_W-1:0]   out_sim_q;
	logic               out_head_q;
	logic               out_done_q;

	logic [NW-1:0]    n_words;
	logic [WW-1:0]    last_w;
	logic             cmd_fire;
	logic             cfg_wr;
	logic             load_ok;
	logic             load_last;
	logic [WW:0]      wp_inc;
	logic             res_load;
	logic             list_we;
	logic [MW:0]      list_raddr;
	logic [MW-1:0]    list_rd;
	logic [FP_WORD_W-1:0] word_a;
	logic [FP_WORD_W-1:0] word_b;
	logic [ONES_W-1:0] ones_a;
	logic [ONES_W-1:0] ones_b;
	sim_req_t         sim_req;
	sim_rsp_t         sim_rsp;
	logic [SIM_W-1:0] sim_val;

	// words in effect: zero acts as one, large values clip to the store width
	always_comb begin
		if (wpp_q == '0) begin
			n_words = NW'(1);
		end else if (32'(wpp_q) > MAX_WORDS) begin
			n_words = NW'(MAX_WORDS);
		end else begin
			n_words = NW'(wpp_q);
		end
	end
	assign last_w = WW'(n_words - NW'(1));

	// ---------------- APB configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpp_q   <= WPP_W'(64);
			thr_q   <= THR_W'(39322);
			limit_q <= LIMIT_W'(1023);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WPP:   wpp_q   <= pwdata[WPP_W-1:0];
				REG_THR:   thr_q   <= pwdata[THR_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WPP:   prdata = 32'(wpp_q);
			REG_THR:   prdata = 32'(thr_q);
			REG_LIMIT: prdata = 32'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------- command side ----------------
	assign cmd.ready = state_q == ST_IDLE;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign load_ok   = cmd_fire && (cmd.func == FUNC_LOAD) && !started_q &&
		(32'(loaded_q) < MAX_MOLECULES);
	assign wp_inc    = {1'b0, wp_q} + (WW+1)'(1);
	assign load_last = (NW+1)'(wp_inc) >= (NW+1)'(n_words);

	// ---------------- memories ----------------
	tlc_print_mem #(.MW(MW), .WW(WW)) u_print (
		.clk         (clk),
		.we          (load_ok),
		.waddr       ({loaded_q[MW-1:0], wp_q}),
		.wdata       (cmd.fp_word),
		.raddr_a     ({head_q, w_q}),
		.raddr_b     ({cand_q, w_q}),
		.rdata_a     (word_a),
		.rdata_b     (word_b),
		.ones_we     (load_ok && load_last),
		.ones_waddr  (loaded_q[MW-1:0]),
		.ones_wdata  (cmd.bit_count),
		.ones_raddr_a(head_q),
		.ones_raddr_b(cand_q),
		.ones_rdata_a(ones_a),
		.ones_rdata_b(ones_b)
	);

	// head reads list entry 0, scanning reads the current position
	assign list_raddr = (state_q == ST_HEAD) ? {bank_q, MW'(0)} : {bank_q, scan_q[MW-1:0]};
	assign list_we    = (state_q == ST_CWAIT) && sim_rsp.done && !sim_rsp.joins && !hmode_q;

	tlc_list_mem #(.MW(MW)) u_list (
		.clk  (clk),
		.we   (list_we),
		.waddr({~bank_q, kept_q[MW-1:0]}),
		.wdata(cand_q),
		.raddr(list_raddr),
		.rdata(list_rd)
	);

	// ---------------- similarity unit ----------------
	assign sim_req.start     = state_q == ST_CGO;
	assign sim_req.force_sim = hmode_q;

	tlc_sim #(.IW(IW)) u_sim (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sim_req),
		.inter (acc_q),
		.ones_a(ones_a),
		.ones_b(ones_b),
		.thr   (thr_q),
		.rsp   (sim_rsp),
		.sim   (sim_val)
	);

	// ---------------- sequencer ----------------
	assign res_load = (state_q == ST_RES) && (!out_vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			loaded_q  <= '0;
			wp_q      <= '0;
			rem_q     <= '0;
			kept_q    <= '0;
			scan_q    <= '0;
			cc_q      <= '0;
			started_q <= 1'b0;
			first_q   <= 1'b0;
			bank_q    <= 1'b0;
			hmode_q   <= 1'b0;
			done_q    <= 1'b0;
			rv_s1     <= 1'b0;
			head_q    <= '0;
		end else begin
			rv_s1 <= state_q == ST_CMP;
			unique case (state_q)
				ST_IDLE: begin
					if (load_ok) begin
						// a word arriving when the store is full or after the first pull is dropped
						if (load_last) begin
							wp_q     <= '0;
							loaded_q <= loaded_q + LW'(1);
						end else begin
							wp_q <= wp_inc[WW-1:0];
						end
					end
					if (cmd_fire && cmd.func == FUNC_PULL) begin
						if (!started_q) begin
							rem_q     <= loaded_q;
							kept_q    <= '0;
							scan_q    <= '0;
							cc_q      <= '0;
							started_q <= 1'b1;
							first_q   <= 1'b1;
							bank_q    <= 1'b0;
						end
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (scan_q != '0 && scan_q < rem_q) begin
						state_q <= ST_MWAIT;
					end else begin
						if (scan_q != '0) begin
							// pass over: survivors become the current list
							bank_q  <= ~bank_q;
							first_q <= 1'b0;
							rem_q   <= kept_q;
							kept_q  <= '0;
							scan_q  <= '0;
							cc_q    <= cc_q + LW'(1);
						end
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (rem_q == '0 || 32'(cc_q) > 32'(limit_q)) begin
						done_q  <= 1'b1;
						state_q <= ST_RES;
					end else begin
						state_q <= ST_HWAIT;
					end
				end
				ST_HWAIT: begin
					head_q  <= first_q ? MW'(0) : list_rd;
					scan_q  <= LW'(1);
					kept_q  <= '0;
					hmode_q <= 1'b1;
					state_q <= ST_CMP;
				end
				ST_MWAIT: begin
					scan_q  <= scan_q + LW'(1);
					hmode_q <= 1'b0;
					state_q <= ST_CMP;
				end
				ST_CMP:   if (w_q == last_w) state_q <= ST_CDRN;
				ST_CDRN:  state_q <= ST_CGO;
				ST_CGO:   state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (sim_rsp.done) begin
						if (sim_rsp.joins || hmode_q) begin
							done_q  <= 1'b0;
							state_q <= ST_RES;
						end else begin
							kept_q  <= kept_q + LW'(1);
							state_q <= ST_CHK;
						end
					end
				end
				ST_RES:   if (res_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// candidate select and word-serial intersection count
	always_ff @(posedge clk) begin
		if (state_q == ST_HWAIT) begin
			cand_q <= first_q ? MW'(0) : list_rd;
		end else if (state_q == ST_MWAIT) begin
			cand_q <= first_q ? scan_q[MW-1:0] : list_rd;
		end
		if (state_q == ST_HWAIT || state_q == ST_MWAIT) begin
			w_q   <= '0;
			acc_q <= '0;
		end else begin
			if (state_q == ST_CMP) begin
				w_q <= w_q + WW'(1);
			end
			if (rv_s1) begin
				acc_q <= acc_q + IW'(popcount16(word_a & word_b));
			end
		end
		if (state_q == ST_CWAIT && sim_rsp.done) begin
			simr_q <= sim_val;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_cl_q   <= done_q ? '0 : CLUST_W'(cc_q);
			out_mol_q  <= done_q ? '0 : MOL_W'(cand_q);
			out_sim_q  <= done_q ? '0 : simr_q;
			out_head_q <= done_q ? 1'b0 : hmode_q;
			out_done_q <= done_q;
		end
	end

	assign res.valid           = out_vld_q;
	assign res.cluster_number  = out_cl_q;
	assign res.molecule_number = out_mol_q;
	assign res.similarity      = out_sim_q;
	assign res.is_head         = out_head_q;
	assign res.done_res        = out_done_q;

	// ---------------- checks ----------------
	`TLC_ASSERT_NOW(a_scan_in_list, 1'b1, scan_q <= rem_q, "scan position past list end")
	`TLC_ASSERT_NOW(a_kept_le_scan, 1'b1, kept_q <= scan_q, "more survivors than scanned")
	`TLC_ASSERT_NOW(a_sim_done_wait, sim_rsp.done, state_q == ST_CWAIT,
		"similarity result with no waiting compare")
	`TLC_ASSERT_NEXT(a_res_loaded, res_load, out_vld_q, "result beat not presented")

endmodule

>>> tb/tlc_checker.sv
`timescale 1ns / 100ps

module tlc_checker import tlc_pkg::*; #(
	parameter int MAX_MOLECULES = 1024,
	parameter int MAX_WORDS     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tlc_cmd_if          cmd,
	tlc_res_if          res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [CLUST_W-1:0] cluster_number;
		logic [MOL_W-1:0]   molecule_number;
		logic [SIM_W-1:0]   similarity;
		logic               is_head;
		logic               done_res;
	} member_rec_t;

	logic [FP_WORD_W-1:0] print_mem [0:MAX_MOLECULES*MAX_WORDS-1];
	logic [ONES_W-1:0]    ones_mem  [0:MAX_MOLECULES-1];
	int unsigned          cur_list  [0:MAX_MOLECULES-1];
	int unsigned          nxt_list  [0:MAX_MOLECULES-1];
	int unsigned n_loaded, word_ptr, remaining, kept, scan_pos, cluster_cnt, head_mol;
	bit          clustering;

	logic [WPP_W-1:0]   wpp;
	logic [THR_W-1:0]   threshold;
	logic [LIMIT_W-1:0] limit;

	member_rec_t expected_recs [$];

	function automatic int unsigned eff_words();
		if (wpp == 0) return 1;
		if (wpp > MAX_WORDS) return MAX_WORDS;
		return wpp;
	endfunction

	// tanimoto similarity by integer division, join test by cross multiplication
	function automatic void tanimoto(input int unsigned a, input int unsigned b,
			output int unsigned sim, output bit joins);
		int unsigned inter;
		longint uni;
		longint q;
		inter = 0;
		for (int w = 0; w < eff_words(); w++)
			inter += $countones(print_mem[a*MAX_WORDS+w] & print_mem[b*MAX_WORDS+w]);
		uni = longint'(ones_mem[a]) + longint'(ones_mem[b]) - longint'(inter);
		if (uni <= 0) begin
			sim = 0;
			joins = 0;
			return;
		end
		q = (longint'(inter) * 65536) / uni;
		sim = (q > 65536) ? 65536 : int'(q);
		joins = longint'(inter) * 65536 > longint'(threshold) * uni;
	endfunction

	function automatic void load_word(input logic [FP_WORD_W-1:0] w, input logic [ONES_W-1:0] c);
		if (clustering || n_loaded >= MAX_MOLECULES) return;
		if (word_ptr >= MAX_WORDS) word_ptr = 0;
		print_mem[n_loaded*MAX_WORDS+word_ptr] = w;
		word_ptr++;
		if (word_ptr >= eff_words()) begin
			ones_mem[n_loaded] = c;
			n_loaded++;
			word_ptr = 0;
		end
	endfunction

	function automatic member_rec_t next_member();
		member_rec_t r;
		int unsigned m, sim;
		bit joins;
		r = '0;
		if (!clustering) begin
			for (int i = 0; i < n_loaded; i++) cur_list[i] = i;
			remaining = n_loaded;
			kept = 0;
			scan_pos = 0;
			cluster_cnt = 0;
			clustering = 1;
		end
		if (scan_pos != 0) begin
			while (scan_pos < remaining && scan_pos < MAX_MOLECULES) begin
				m = cur_list[scan_pos];
				scan_pos++;
				tanimoto(head_mol, m, sim, joins);
				if (joins) begin
					r.cluster_number  = CLUST_W'(cluster_cnt);
					r.molecule_number = MOL_W'(m);
					r.similarity      = SIM_W'(sim);
					return r;
				end
				if (kept < MAX_MOLECULES) begin
					nxt_list[kept] = m;
					kept++;
				end
			end
			for (int i = 0; i < kept; i++) cur_list[i] = nxt_list[i];
			remaining = kept;
			kept = 0;
			scan_pos = 0;
			cluster_cnt++;
		end
		if (remaining == 0 || cluster_cnt > limit) begin
			r.done_res = 1'b1;
			return r;
		end
		head_mol = cur_list[0];
		scan_pos = 1;
		kept = 0;
		tanimoto(head_mol, head_mol, sim, joins);
		r.cluster_number  = CLUST_W'(cluster_cnt);
		r.molecule_number = MOL_W'(head_mol);
		r.similarity      = SIM_W'(sim);
		r.is_head         = 1'b1;
		return r;
	endfunction

	task automatic report(input string field, input int unsigned exp_v, input int unsigned got_v);
		$display("mismatch on %s: expected %0d, got %0d at %0t", field, exp_v, got_v, $realtime);
		fail_count++;
	endtask

	assign pending = expected_recs.size();

	always @(posedge clk or negedge arst_n) begin
		member_rec_t e;
		if (!arst_n) begin
			n_loaded = 0; word_ptr = 0; remaining = 0; kept = 0; scan_pos = 0;
			cluster_cnt = 0; head_mol = 0; clustering = 0;
			wpp = 64; threshold = 39322; limit = 1023;
			expected_recs.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WPP:   wpp = pwdata[WPP_W-1:0];
					REG_THR:   threshold = pwdata[THR_W-1:0];
					REG_LIMIT: limit = pwdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.func == FUNC_LOAD) load_word(cmd.fp_word, cmd.bit_count);
				else expected_recs.push_back(next_member());
			end
			if (res.valid && res.ready) begin
				if (expected_recs.size() == 0) begin
					report("result beats pending", 0, 1);
				end else begin
					e = expected_recs.pop_front();
					if (res.cluster_number !== e.cluster_number)
						report("cluster_number", e.cluster_number, res.cluster_number);
					if (res.molecule_number !== e.molecule_number)
						report("molecule_number", e.molecule_number, res.molecule_number);
					if (res.similarity !== e.similarity)
						report("similarity", e.similarity, res.similarity);
					if (res.is_head !== e.is_head) report("is_head", e.is_head, res.is_head);
					if (res.done_res !== e.done_res) report("done_res", e.done_res, res.done_res);
				end
			end
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import tlc_pkg::*;

	localparam int     N_MOLS      = 200;
	localparam int     N_BEATS     = 650;
	localparam longint CYCLE_LIMIT = 4_000_000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	// idle mix: 0 = receiver sparse, 1 = sender sparse, 2 = no idling
	int          idle_mode;
	int          beats_sent;
	longint      cycles;

	// cluster templates so that real clusters form
	logic [15:0] templates [0:31];

	tlc_cmd_if cmd_bus ();
	tlc_res_if res_bus ();

	tanimoto_leader_clustering_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tlc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_bus),
		.res        (res_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog against a hung pull
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver stalls, redrawn every cycle
	always @(negedge clk) begin
		case (idle_mode)
			0:       res_bus.ready <= ($urandom_range(0, 99) >= 68);
			1:       res_bus.ready <= ($urandom_range(0, 99) >= 26);
			default: res_bus.ready <= 1'b1;
		endcase
	end

	task automatic send_beat(input logic func, input logic [15:0] word, input logic [10:0] cnt);
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 68 : 0;
		while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
		cmd_bus.valid     = 1'b1;
		cmd_bus.func      = func;
		cmd_bus.fp_word   = word;
		cmd_bus.bit_count = cnt;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		@(negedge clk);
		cmd_bus.valid = 1'b0;
		beats_sent++;
		// switch the idle mix by thirds of the run
		if (beats_sent == N_BEATS / 3) idle_mode = 1;
		if (beats_sent == 2 * N_BEATS / 3) idle_mode = 2;
	endtask

	// the word's own popcount most of the time, sometimes an inconsistent count
	task automatic load_print(input logic [15:0] word);
		logic [10:0] cnt;
		cnt = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1024)) : 11'($countones(word));
		send_beat(FUNC_LOAD, word, cnt);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// block idle: all results back, plus slack for a load still in flight
	task automatic wait_quiet();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pull_run(input int count);
		repeat (count) send_beat(FUNC_PULL, 16'($urandom), 11'($urandom));
	endtask

	initial begin
		logic [15:0] w;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		cmd_bus.valid     = 1'b0;
		cmd_bus.func      = FUNC_LOAD;
		cmd_bus.fp_word   = '0;
		cmd_bus.bit_count = '0;
		res_bus.ready     = 1'b0;
		idle_mode         = 0;
		beats_sent        = 0;
		cycles            = 0;
		foreach (templates[i]) templates[i] = 16'($urandom);
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// register extremes while nothing is loaded, then one word per print
		reg_write(REG_WPP, 127);
		reg_write(REG_THR, 65536);
		reg_write(REG_LIMIT, 1023);
		reg_write(REG_WPP, 0);

		// directed prints: empty, full, saturated and inconsistent counts
		send_beat(FUNC_LOAD, 16'h0000, 11'd0);
		send_beat(FUNC_LOAD, 16'hFFFF, 11'd16);
		send_beat(FUNC_LOAD, 16'hFFFF, 11'd1024);
		send_beat(FUNC_LOAD, 16'hFFFF, 11'd0);
		send_beat(FUNC_LOAD, 16'h0001, 11'd0);
		send_beat(FUNC_LOAD, 16'hAAAA, 11'd8);
		send_beat(FUNC_LOAD, 16'h5555, 11'd1);
		send_beat(FUNC_LOAD, 16'h8000, 11'd1);

		// zero word count acts as one, switch to a literal one half way
		for (int i = 8; i < N_MOLS; i++) begin
			if (i == N_MOLS / 2) begin
				wait_quiet();
				reg_write(REG_WPP, 1);
			end
			if ($urandom_range(0, 9) == 0) begin
				w = 16'($urandom);
			end else begin
				w = templates[$urandom_range(0, 31)];
				if ($urandom_range(0, 1)) w[$urandom_range(0, 15)] ^= 1'b1;
			end
			load_print(w);
		end

		// stop after the very first cluster
		wait_quiet();
		reg_write(REG_THR, 39322);
		reg_write(REG_LIMIT, 0);
		pull_run(40);

		// threshold of one: only a member whose similarity exceeds one joins
		wait_quiet();
		reg_write(REG_LIMIT, 1023);
		reg_write(REG_THR, 65536);
		pull_run(12);

		// any overlap joins
		wait_quiet();
		reg_write(REG_THR, 0);
		reg_write(REG_WPP, 0);
		pull_run(30);

		for (int ph = 0; ph < 8; ph++) begin
			wait_quiet();
			reg_write(REG_WPP, $urandom_range(0, 1));
			reg_write(REG_THR, $urandom_range(20000, 62000));
			reg_write(REG_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : 1023);
			pull_run(25);
		end

		// make sure the list drains, then pull past the end
		wait_quiet();
		reg_write(REG_LIMIT, 1023);
		reg_write(REG_THR, 0);
		pull_run(160);

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_cmd_if.sv
rtl/tlc_res_if.sv
rtl/tlc_print_mem.sv
rtl/tlc_list_mem.sv
rtl/tlc_sim.sv
rtl/tanimoto_leader_clustering_core.sv
tb/tlc_checker.sv
tb/tb.sv
